/* src/srap_pkg.sv */
// Shared types and constants for the STUN response address parser.
package srap_pkg;

   localparam int MAX_DATAGRAM_DEFAULT = 512;

   // Byte offsets within the STUN header
   localparam int COOKIE_START = 4;
   localparam int HEADER_LEN   = 20;

   localparam logic [31:0] MAGIC_COOKIE     = 32'h2112_A442;
   localparam logic [15:0] PORT_XOR_MASK    = 16'h2112;
   localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
   localparam logic [15:0] MIN_ADDR_VAL_LEN = 16'd8;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TXID_UPPER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TXID_LOWER = 1'b1;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_CAPTURE,
      PH_SKIP,
      PH_DONE
   } walk_phase_type;

   typedef enum logic [1:0] {
      ST_FOUND      = 2'd0,
      ST_NO_ADDRESS = 2'd1,
      ST_IGNORED    = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] port;
      logic [31:0] ip;
      status_type  status;
   } result_type;

endpackage

/* src/srap_parse.sv */
// Per-datagram header check and attribute walk, one byte per step.
module srap_parse #(
   parameter int MAX_DATAGRAM = srap_pkg::MAX_DATAGRAM_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                last,
   input  logic [31:0]         txid_upper,
   input  logic [63:0]         txid_lower,
   output srap_pkg::result_type result
);
   import srap_pkg::*;

   localparam int PosW = $clog2(MAX_DATAGRAM + 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic            match_ff, match_in;
   walk_phase_type  phase_ff, phase_in;
   logic [15:0]     type_ff, type_in;
   logic [15:0]     len_ff, len_in;
   logic [16:0]     rem_ff, rem_in;
   logic [15:0]     port_ff, port_in;
   logic [31:0]     ip_ff, ip_in;
   logic            found_ff, found_in;

   logic [127:0] hdr_vec;
   logic [3:0]   hdr_idx;
   logic [7:0]   hdr_byte;
   logic [16:0]  rem_inc;
   logic [16:0]  skip_len;

   assign hdr_vec  = {MAGIC_COOKIE, txid_upper, txid_lower};
   assign hdr_idx  = 4'(pos_ff - PosW'(COOKIE_START));
   // byte 0 of the header window sits in the top bits
   assign hdr_byte = hdr_vec[{~hdr_idx, 3'b000} +: 8];
   assign rem_inc  = rem_ff + 17'd1;

   always_comb begin
      pos_in   = pos_ff;
      match_in = match_ff;
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      port_in  = port_ff;
      ip_in    = ip_ff;
      found_in = found_ff;
      skip_len = '0;
      result   = '{port: '0, ip: '0, status: ST_IGNORED};

      if (step) begin
         if (pos_ff < PosW'(MAX_DATAGRAM)) begin
            if (pos_ff >= PosW'(COOKIE_START) && pos_ff < PosW'(HEADER_LEN)) begin
               if (data_byte != hdr_byte) match_in = 1'b0;
            end else if (pos_ff >= PosW'(HEADER_LEN)) begin
               case (phase_ff)
                  PH_HEADER: begin
                     if (rem_ff < 17'd2) type_in = {type_ff[7:0], data_byte};
                     else                len_in  = {len_ff[7:0], data_byte};
                     rem_in = rem_inc;
                     if (rem_inc >= 17'd4) begin
                        if (type_in == ATTR_XOR_MAPPED && len_in >= MIN_ADDR_VAL_LEN) begin
                           phase_in = PH_CAPTURE;
                           rem_in   = '0;
                        end else begin
                           // value padded up to a 4-byte boundary
                           skip_len = (17'(len_in) + 17'd3) & ~17'd3;
                           rem_in   = skip_len;
                           phase_in = (skip_len != '0) ? PH_SKIP : PH_HEADER;
                        end
                     end
                  end
                  PH_CAPTURE: begin
                     if (rem_ff == 17'd2 || rem_ff == 17'd3)
                        port_in = {port_ff[7:0], data_byte};
                     else if (rem_ff >= 17'd4)
                        ip_in = {ip_ff[23:0], data_byte};
                     rem_in = rem_inc;
                     if (rem_inc >= 17'd8) begin
                        found_in = 1'b1;
                        phase_in = PH_DONE;
                     end
                  end
                  PH_SKIP: begin
                     if (rem_ff != '0) rem_in = rem_ff - 17'd1;
                     if (rem_in == '0) begin
                        phase_in = PH_HEADER;
                        type_in  = '0;
                        len_in   = '0;
                     end
                  end
                  default: ;
               endcase
            end
            pos_in = pos_ff + PosW'(1);
         end

         if (last) begin
            if (pos_in < PosW'(HEADER_LEN) || !match_in)
               result = '{port: '0, ip: '0, status: ST_IGNORED};
            else if (found_in)
               result = '{port: port_in ^ PORT_XOR_MASK, ip: ip_in ^ MAGIC_COOKIE,
                          status: ST_FOUND};
            else
               result = '{port: '0, ip: '0, status: ST_NO_ADDRESS};

            pos_in   = '0;
            match_in = 1'b1;
            phase_in = PH_HEADER;
            type_in  = '0;
            len_in   = '0;
            rem_in   = '0;
            port_in  = '0;
            ip_in    = '0;
            found_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         match_ff <= 1'b1;
         phase_ff <= PH_HEADER;
         type_ff  <= '0;
         len_ff   <= '0;
         rem_ff   <= '0;
         port_ff  <= '0;
         ip_ff    <= '0;
         found_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         match_ff <= match_in;
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         port_ff  <= port_in;
         ip_ff    <= ip_in;
         found_ff <= found_in;
      end
   end

endmodule

/* src/stun_response_address_parser.sv */
// Top level of the STUN binding response XOR-MAPPED-ADDRESS parser.
// Streams a received STUN datagram in one byte per transaction (tlast on the
// final byte), checks the magic cookie and the 96-bit transaction ID set
// through the csr_ port, walks the attributes and returns one result
// transaction per datagram: found (with the decoded IPv4 address and port),
// no mapped address, or ignored (short datagram or header mismatch).
// Throughput is one byte per clock while the input side does not stall: each
// byte passes through an input register, the combinational parser logic and,
// for a final byte, a result register, so rsp_tvalid is driven from the result
// register and rises only after the final byte has left the input register.
// The input side stalls only when a final byte waits in the input register
// while the result register still holds a result not yet taken. Bytes past
// MAX_DATAGRAM are dropped, but their tlast still closes the datagram.
// Transaction ID registers must only be written while no datagram is in flight.
module stun_response_address_parser #(
   parameter int MAX_DATAGRAM = srap_pkg::MAX_DATAGRAM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // datagram byte stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  logic                                req_tlast,  // end_of_datagram
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] status, [33:2] public_ip, [49:34] public_port, [55:50] zero
   output logic [55:0]                         rsp_tdata,
   // configuration writes
   input  logic                                csr_we,
   input  logic [srap_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srap_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import srap_pkg::*;

   // transaction ID registers
   logic [31:0] txid_upper_ff, txid_upper_in;
   logic [63:0] txid_lower_ff, txid_lower_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   result_type parse_result;
   logic       out_free;
   logic       advance;

   // A non-final byte always moves on; a final byte needs the result slot.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      txid_upper_in = txid_upper_ff;
      txid_lower_in = txid_lower_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TXID_UPPER: txid_upper_in = csr_wdata[31:0];
            CSR_TXID_LOWER: txid_lower_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   srap_parse #(
      .MAX_DATAGRAM(MAX_DATAGRAM)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .last       (in_last_ff),
      .txid_upper (txid_upper_ff),
      .txid_lower (txid_lower_ff),
      .result     (parse_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = parse_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         txid_upper_ff <= '0;
         txid_lower_ff <= '0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         txid_upper_ff <= txid_upper_in;
         txid_lower_ff <= txid_lower_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.port, rsp_data_ff.ip, rsp_data_ff.status};

   // Address fields are zero unless an address was found.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_FOUND)
         |-> (rsp_data_ff.ip == '0 && rsp_data_ff.port == '0))
      else $error("address fields nonzero on a not-found result");

   // Backpressure only comes from a final byte blocked by a full result slot.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked final byte");

   // A byte held in the input register is not lost or changed.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance)
         |=> (in_valid_ff && in_last_ff && $stable(in_byte_ff)))
      else $error("held input byte lost");

endmodule
